// ===== rtl/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// shared types and constants for the cursor array list core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cal_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // register byte offsets
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_START  = 3'd2,
    REQ_END    = 3'd3,
    REQ_PREV   = 3'd4,
    REQ_NEXT   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic [CNT_W-1:0]        cursor;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cal_cell.sv =====
// ----------------------------------------------------------------------------
// cal_cell
// one list slot: holds an entry and shifts with its neighbors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cal_cell
  import cal_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_ctrl_t              ctrl,
  input  wire logic [CNT_W-1:0]        idx,
  input  wire logic signed [VAL_W-1:0] lower_data,
  input  wire logic signed [VAL_W-1:0] upper_data,
  output logic signed [VAL_W-1:0]      data
);

  logic signed [VAL_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (idx == ctrl.cursor) begin
        data_next = ctrl.value;
      end else if (idx > ctrl.cursor) begin
        data_next = lower_data;
      end
    end else if (ctrl.rem) begin
      if (idx >= ctrl.cursor) begin
        data_next = upper_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== rtl/cal_cfg.sv =====
// ----------------------------------------------------------------------------
// cal_cfg
// apb register slice holding the capacity limit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cal_cfg
  import cal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CAP_W-1:0]  capacity
);

  logic hit;

  // word select only, byte lanes ignored
  assign hit    = (paddr[ADDR_W-1:2] == REG_CAPACITY[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign prdata = hit ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cursor_array_list_core.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list_core
// ordered list of signed 32-bit values with a cursor, kept in a chain of cells
// ----------------------------------------------------------------------------
//  channel   | ports                                     | handshake
//  ----------+-------------------------------------------+------------------------
//  request   | req_type, value_in                        | start && !busy
//  result    | status, value_out, cursor_pos, entry_count| done, one cycle, no stall
//  config    | psel, penable, pwrite, paddr, pwdata, ... | apb, pready tied high
//
//  one request per clock; its result shows with done on the next cycle
//  every cell of the chain updates in the same edge; busy stays low
//  synchronous active-high reset clears count, cursor and done and sets capacity
//  to CAP_RESET; list entries are not reset
//  the receiver cannot stall: each result transfer lasts exactly one cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cursor_array_list_core
  import cal_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // request
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              req_type,
  input  wire logic signed [VAL_W-1:0] value_in,
  // result
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [VAL_W-1:0]      value_out,
  output logic [4:0]                   cursor_pos,
  output logic [4:0]                   entry_count,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready
);

  // list state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] cursor_next;
  logic [CAP_W-1:0] capacity;

  logic                    accept;
  logic                    full;
  logic                    at_end;
  status_t                 st_next;
  logic signed [VAL_W-1:0] rem_value;
  logic signed [VAL_W-1:0] val_next;
  cell_ctrl_t              ctrl;

  logic signed [VAL_W-1:0] cell_data [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // capacity above the chain length is clamped by the second compare
  assign full   = (7'(count) >= 7'(capacity)) || (count >= CNT_W'(DEPTH));
  assign at_end = (cursor >= count);

  // value under the cursor, only meaningful when not at the end
  assign rem_value = cell_data[cursor[IDX_W-1:0]];

  cal_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // request decode: new count and cursor, status and what the cells do
  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    st_next     = ST_OK;
    val_next    = '0;
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    ctrl.cursor = cursor;
    ctrl.value  = value_in;
    case (req_t'(req_type))
      REQ_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (at_end) begin
          st_next = ST_EMPTY;
        end else begin
          ctrl.rem   = accept;
          val_next   = rem_value;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_START: cursor_next = '0;
      REQ_END:   cursor_next = count;
      REQ_PREV: begin
        if (cursor != '0) begin
          cursor_next = cursor - CNT_W'(1);
        end
      end
      REQ_NEXT: begin
        if (!at_end) begin
          cursor_next = cursor + CNT_W'(1);
        end
      end
      default: ;  // unused codes leave everything as is
    endcase
  end

  // the chain: each cell sees its lower and upper neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] lower;
    logic signed [VAL_W-1:0] upper;

    if (g == 0) begin : g_first
      assign lower = value_in;
    end else begin : g_lower
      assign lower = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_upper
      assign upper = cell_data[g+1];
    end

    cal_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (CNT_W'(g)),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[g])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
      done   <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count  <= count_next;
        cursor <= cursor_next;
      end
    end
  end

  // result registers, valid only with done
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= st_next;
      value_out   <= val_next;
      cursor_pos  <= 5'(cursor_next);
      entry_count <= 5'(count_next);
    end
  end

  // checks

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("cursor beyond entry count");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond chain length");

  a_refused_insert_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_INSERT && full) |=> (count == $past(count)))
    else $error("refused insert changed the count");

  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |-> $past(accept))
    else $error("result strobe without a request");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_REMOVE && !at_end) |=>
      (count == $past(count) - CNT_W'(1)))
    else $error("remove did not shrink the list");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cursor array list core
// ----------------------------------------------------------------------------
// requests go in on the start/busy handshake and each one is predicted by a
// scoreboard that keeps its own copy of the list, cursor, count and capacity.
// every done strobe is checked field by field against the oldest prediction.
// a short directed pass covers the edge cases, then random phases run with
// varied capacity settings and request mixes. capacity is only rewritten
// over the apb port while the core is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cal_pkg::*;

  // request codes the core has no operation for, and a register slot past
  // the only one that exists
  localparam logic [2:0]        REQ_SPARE6  = 3'd6;
  localparam logic [2:0]        REQ_SPARE7  = 3'd7;
  localparam logic [ADDR_W-1:0] REG_SPARE   = 3'd4;

  localparam int FILL  = 0;
  localparam int DRAIN = 1;
  localparam int MIXED = 2;

  localparam int PHASES      = 15;
  localparam int PHASE_ITEMS = 50;
  localparam int QUIET_FROM  = 13;    // last phases run without gaps
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    status_t                 st;
    logic signed [VAL_W-1:0] val;
    logic [4:0]              cur;
    logic [4:0]              cnt;
  } answer_t;

  // --------------------------------------------------------------------------
  // list predictor and store of pending answers
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic signed [VAL_W-1:0] cells [DEPTH];
    int                      count;
    int                      cur;
    int                      cap;
    int                      errors;
    answer_t                 answers [$];

    function new();
      count  = 0;
      cur    = 0;
      cap    = int'(CAP_RESET);
      errors = 0;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40)
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    function void set_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      if (addr == REG_CAPACITY)
        cap = int'(data[CAP_W-1:0]);
    endfunction

    // one request transfer accepted: update the list and queue its answer
    function void note_request(logic [2:0] req, logic signed [VAL_W-1:0] val);
      answer_t a;
      int      lim;
      int      i;
      a.st  = ST_OK;
      a.val = '0;
      lim   = (cap > DEPTH) ? DEPTH : cap;
      case (req)
        REQ_INSERT: begin
          if (count >= lim) begin
            a.st = ST_FULL;
          end else begin
            for (i = count; i > cur; i--)
              cells[i] = cells[i-1];
            cells[cur] = val;
            count++;
          end
        end
        REQ_REMOVE: begin
          if (cur >= count) begin
            a.st = ST_EMPTY;
          end else begin
            a.val = cells[cur];
            for (i = cur; i + 1 < count; i++)
              cells[i] = cells[i+1];
            count--;
          end
        end
        REQ_START: cur = 0;
        REQ_END:   cur = count;
        REQ_PREV:  if (cur != 0) cur--;
        REQ_NEXT:  if (cur < count) cur++;
        default: ;
      endcase
      a.cur = 5'(cur);
      a.cnt = 5'(count);
      answers.push_back(a);
    endfunction

    task check_result(logic [1:0] st, logic [VAL_W-1:0] val, logic [4:0] c, logic [4:0] n);
      answer_t a;
      if (answers.size() == 0) begin
        report("result with nothing pending", {30'b0, st}, '0);
        return;
      end
      a = answers.pop_front();
      if (st !== a.st)   report("status", {30'b0, st}, {30'b0, a.st});
      if (val !== a.val) report("value_out", val, a.val);
      if (c !== a.cur)   report("cursor_pos", {27'b0, c}, {27'b0, a.cur});
      if (n !== a.cnt)   report("entry_count", {27'b0, n}, {27'b0, a.cnt});
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [2:0]              req_type;
  logic signed [VAL_W-1:0] value_in;
  logic                    done;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] value_out;
  logic [4:0]              cursor_pos;
  logic [4:0]              entry_count;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  list_scoreboard sb = new();
  int             quiet_cycles = 0;

  cursor_array_list_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .value_in    (value_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .cursor_pos  (cursor_pos),
    .entry_count (entry_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // driving tasks, each entered just after a rising edge
  // --------------------------------------------------------------------------

  // hold the request until the core takes it; start stays high afterward so
  // back-to-back transfers need no extra assignment
  task automatic send(input logic [2:0] req, input logic [VAL_W-1:0] val);
    start    <= 1'b1;
    req_type <= req;
    value_in <= val;
    do @(posedge clk); while (busy);
    sb.note_request(req, val);
  endtask

  // sender gap: start low and junk on the payload
  task automatic gap(input int cycles);
    start    <= 1'b0;
    req_type <= 3'($urandom);
    value_in <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // let every pending result come back
  task automatic drain_core();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  // apb write, then a read back of the same slot
  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(addr, data);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only the capacity slot has a defined read value
    if (addr == REG_CAPACITY && prdata !== DATA_W'(sb.cap))
      sb.report("capacity read back", prdata, DATA_W'(sb.cap));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // capacity goes in the low bits; upper bits are noise the core must drop
  task automatic set_capacity(input int cap);
    drain_core();
    cfg_write(REG_CAPACITY, {(DATA_W-CAP_W)'($urandom), CAP_W'(cap)});
  endtask

  // --------------------------------------------------------------------------
  // result monitor and watchdog
  // --------------------------------------------------------------------------
  // outputs are read at the edge that ends the strobe cycle, so they still
  // hold their pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result(status, value_out, cursor_pos, entry_count);
      if ((start && !busy) || done) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         caps  [5];
    int         modes [5];
    int         phase;
    int         k;
    int         r;
    int         mode;
    int         ins_pct;
    int         rem_pct;
    bit         idling;
    logic [2:0] req;
    logic [31:0] val;

    // opening schedule: above depth, lowered below count, zero, one, full
    caps  = '{31, 5, 0, 1, 16};
    modes = '{FILL, MIXED, MIXED, FILL, FILL};

    rst      <= 1'b1;
    start    <= 1'b0;
    req_type <= REQ_INSERT;
    value_in <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of capacity, read through a rewrite of the same value
    cfg_write(REG_CAPACITY, DATA_W'(CAP_RESET));

    // directed: empty list corner cases
    send(REQ_REMOVE, 32'h1234_5678);   // nothing at the cursor
    send(REQ_PREV,   '0);              // clamp at start
    send(REQ_NEXT,   '0);              // clamp at end of empty list
    // extreme values, each pushed in front of the last
    send(REQ_INSERT, 32'h7fff_ffff);
    send(REQ_INSERT, 32'h8000_0000);
    send(REQ_INSERT, 32'h0000_0000);
    send(REQ_INSERT, 32'hffff_ffff);
    send(REQ_NEXT,   '0);
    send(REQ_NEXT,   '0);
    send(REQ_PREV,   '0);
    send(REQ_END,    '0);
    send(REQ_NEXT,   '0);              // clamp at count
    send(REQ_REMOVE, '0);              // remove at end
    send(REQ_START,  '0);
    send(REQ_REMOVE, '0);
    send(REQ_SPARE6, 32'hdead_beef);   // unused codes answer ok, no change
    send(REQ_SPARE7, 32'hdead_beef);
    send(REQ_INSERT, 32'h5a5a_5a5a);
    // capacity dropped under the count: inserts refused, list kept
    set_capacity(2);
    send(REQ_INSERT, 32'h0f0f_0f0f);
    send(REQ_REMOVE, '0);
    // capacity zero refuses every insert
    set_capacity(0);
    send(REQ_INSERT, 32'h0000_0001);
    // a write past the only register must be ignored
    drain_core();
    cfg_write(REG_SPARE, 32'h0000_001f);
    send(REQ_END,    '0);
    send(REQ_REMOVE, '0);

    // random phases
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 5) begin
        set_capacity(caps[phase]);
        mode = modes[phase];
      end else begin
        set_capacity(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(1, 16));
        mode = $urandom_range(FILL, MIXED);
      end
      if ($urandom_range(0, 1) == 0) begin
        drain_core();
        cfg_write(REG_SPARE, $urandom);
      end

      ins_pct = (mode == FILL) ? 55 : (mode == DRAIN) ? 20 : 35;
      rem_pct = ins_pct + ((mode == DRAIN) ? 45 : 25);
      // some phases send back to back, the last ones always do
      idling  = (phase < QUIET_FROM) && ($urandom_range(0, 3) != 0);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct)      req = REQ_INSERT;
        else if (r < rem_pct) req = REQ_REMOVE;
        else if (r < 98)      req = 3'($urandom_range(int'(REQ_START), int'(REQ_NEXT)));
        else if (r == 98)     req = REQ_SPARE6;
        else                  req = REQ_SPARE7;

        case ($urandom_range(0, 9))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7fff_ffff;
          2:       val = 32'h0000_0000;
          3:       val = 32'hffff_ffff;
          default: val = $urandom;
        endcase

        if (idling && $urandom_range(0, 3) == 0)
          gap($urandom_range(1, 19));
        send(req, val);
      end
    end

    // wait out the last results, then wait for anything stray
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (5) @(posedge clk);

    if (sb.pending() != 0)
      sb.report("results never arrived", sb.pending(), 0);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
